[src/ipc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types and constants of the IP address text classifier.
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int CHAR_W  = 8;
    localparam int CLASS_W = 2;
    localparam int DIGIT_W = 4;

    // Verdict codes
    localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_V4   = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_V6   = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] ASCII_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] ASCII_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] ASCII_0     = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_9     = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] ASCII_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LF    = 8'h66;

    // Counter limits
    localparam logic [5:0] CHAR_SAT      = 6'd40;
    localparam logic [5:0] V4_MAX_CHARS  = 6'd15;
    localparam logic [5:0] V6_MAX_CHARS  = 6'd39;
    localparam logic [2:0] DOT_SAT       = 3'd4;
    localparam logic [2:0] V4_DOTS       = 3'd3;
    localparam logic [2:0] V4_LEN_SAT    = 3'd4;
    localparam logic [2:0] V4_MAX_DIGITS = 3'd3;
    localparam logic [9:0] V4_MAX_VALUE  = 10'd255;
    localparam logic [3:0] COLON_SAT     = 4'd8;
    localparam logic [3:0] V6_COLONS     = 4'd7;
    localparam logic [2:0] V6_LEN_SAT    = 3'd5;
    localparam logic [2:0] V6_MAX_DIGITS = 3'd4;

    // Token queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        logic               has_char;
        logic               is_last;
        logic               is_dot;
        logic               is_colon;
        logic               is_digit;
        logic               is_hex;
        logic [DIGIT_W-1:0] digit;
    } t_ipc_tok;

endpackage

[src/ipc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_front
// Accepts input bytes and sorts each into a character class token.
// ----------------------------------------------------------------------------
module ipc_front (
    input  logic                        i_valid,
    input  logic [ipc_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_has_char,
    input  logic                        i_is_last,
    input  logic                        i_queue_full,
    output logic                        o_ready,
    output logic                        o_push,
    output ipc_pkg::t_ipc_tok           o_tok
);

    logic w_digit;
    logic w_lower;
    logic w_upper;

    always_comb begin
        w_digit = (i_char_code >= ipc_pkg::ASCII_0) && (i_char_code <= ipc_pkg::ASCII_9);
        w_lower = (i_char_code >= ipc_pkg::ASCII_LA) && (i_char_code <= ipc_pkg::ASCII_LF);
        w_upper = (i_char_code >= ipc_pkg::ASCII_UA) && (i_char_code <= ipc_pkg::ASCII_UF);

        o_tok.has_char = i_has_char;
        o_tok.is_last  = i_is_last;
        o_tok.is_dot   = (i_char_code == ipc_pkg::ASCII_DOT);
        o_tok.is_colon = (i_char_code == ipc_pkg::ASCII_COLON);
        o_tok.is_digit = w_digit;
        o_tok.is_hex   = w_digit || w_lower || w_upper;
        o_tok.digit    = i_char_code[ipc_pkg::DIGIT_W-1:0];
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

endmodule

[src/ipc_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_fifo
// Short token queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module ipc_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ipc_pkg::t_ipc_tok i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output ipc_pkg::t_ipc_tok o_data
);

    ipc_pkg::t_ipc_tok                r_mem [ipc_pkg::FIFO_DEPTH];
    logic [ipc_pkg::FIFO_AW-1:0]      r_wr_ptr;
    logic [ipc_pkg::FIFO_AW-1:0]      r_rd_ptr;
    logic [ipc_pkg::FIFO_AW:0]        r_count;
    logic [ipc_pkg::FIFO_AW:0]        n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == (ipc_pkg::FIFO_AW+1)'(ipc_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

[src/ipc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_back
// Updates the IPv4 and IPv6 checkers per token and registers the verdict.
// ----------------------------------------------------------------------------
module ipc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  ipc_pkg::t_ipc_tok           i_tok,
    output logic                        o_pop,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [ipc_pkg::CLASS_W-1:0] o_out_class
);

    logic [5:0] r_char_total;
    logic       r_v4_ok;
    logic [2:0] r_dot_total;
    logic [2:0] r_v4_len;
    logic [9:0] r_v4_val;
    logic       r_v4_zero;
    logic       r_v6_ok;
    logic [3:0] r_colon_total;
    logic [2:0] r_v6_len;

    logic [5:0] n_char_total;
    logic       n_v4_ok;
    logic [2:0] n_dot_total;
    logic [2:0] n_v4_len;
    logic [9:0] n_v4_val;
    logic       n_v4_zero;
    logic       n_v6_ok;
    logic [3:0] n_colon_total;
    logic [2:0] n_v6_len;

    logic                        r_out_valid;
    logic [ipc_pkg::CLASS_W-1:0] r_out_class;
    logic [ipc_pkg::CLASS_W-1:0] w_class;
    logic                        w_is_v4;
    logic                        w_is_v6;

    function automatic logic f_v4_group_ok(input logic [2:0] len, input logic zero,
                                           input logic [9:0] val);
        f_v4_group_ok = (len != 3'd0) && (len <= ipc_pkg::V4_MAX_DIGITS) &&
                        !(zero && (len > 3'd1)) && (val <= ipc_pkg::V4_MAX_VALUE);
    endfunction

    function automatic logic f_v6_group_ok(input logic [2:0] len);
        f_v6_group_ok = (len != 3'd0) && (len <= ipc_pkg::V6_MAX_DIGITS);
    endfunction

    // A last token may only leave the queue when the output slot can take it.
    assign o_pop = !i_empty && (!i_tok.is_last || !r_out_valid || i_out_ready);

    always_comb begin
        n_char_total  = r_char_total;
        n_v4_ok       = r_v4_ok;
        n_dot_total   = r_dot_total;
        n_v4_len      = r_v4_len;
        n_v4_val      = r_v4_val;
        n_v4_zero     = r_v4_zero;
        n_v6_ok       = r_v6_ok;
        n_colon_total = r_colon_total;
        n_v6_len      = r_v6_len;

        if (i_tok.has_char) begin
            if (r_char_total < ipc_pkg::CHAR_SAT) begin
                n_char_total = r_char_total + 1'b1;
            end

            if (i_tok.is_dot) begin
                if (r_dot_total < ipc_pkg::DOT_SAT) begin
                    n_dot_total = r_dot_total + 1'b1;
                end
                if (!f_v4_group_ok(r_v4_len, r_v4_zero, r_v4_val)) begin
                    n_v4_ok = 1'b0;
                end
                n_v4_len  = '0;
                n_v4_val  = '0;
                n_v4_zero = 1'b0;
            end else if (i_tok.is_digit) begin
                if (r_v4_len == 3'd0) begin
                    n_v4_zero = (i_tok.digit == '0);
                end
                // Value stays below 100 here, so times ten fits in ten bits.
                if (r_v4_len < ipc_pkg::V4_MAX_DIGITS) begin
                    n_v4_val = {r_v4_val[6:0], 3'b000} + {r_v4_val[8:0], 1'b0} +
                               {6'd0, i_tok.digit};
                end
                if (r_v4_len < ipc_pkg::V4_LEN_SAT) begin
                    n_v4_len = r_v4_len + 1'b1;
                end
            end else begin
                n_v4_ok = 1'b0;
            end

            if (i_tok.is_colon) begin
                if (r_colon_total < ipc_pkg::COLON_SAT) begin
                    n_colon_total = r_colon_total + 1'b1;
                end
                if (!f_v6_group_ok(r_v6_len)) begin
                    n_v6_ok = 1'b0;
                end
                n_v6_len = '0;
            end else if (i_tok.is_hex) begin
                if (r_v6_len < ipc_pkg::V6_LEN_SAT) begin
                    n_v6_len = r_v6_len + 1'b1;
                end
            end else begin
                n_v6_ok = 1'b0;
            end
        end

        w_is_v4 = n_v4_ok && (n_dot_total == ipc_pkg::V4_DOTS) &&
                  (n_char_total <= ipc_pkg::V4_MAX_CHARS) &&
                  f_v4_group_ok(n_v4_len, n_v4_zero, n_v4_val);
        w_is_v6 = n_v6_ok && (n_colon_total == ipc_pkg::V6_COLONS) &&
                  (n_char_total <= ipc_pkg::V6_MAX_CHARS) && f_v6_group_ok(n_v6_len);

        priority if (n_char_total == '0) begin
            w_class = ipc_pkg::CLASS_NONE;
        end else if (w_is_v4) begin
            w_class = ipc_pkg::CLASS_V4;
        end else if (w_is_v6) begin
            w_class = ipc_pkg::CLASS_V6;
        end else begin
            w_class = ipc_pkg::CLASS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_tok.is_last)) begin
            r_char_total  <= '0;
            r_v4_ok       <= 1'b1;
            r_dot_total   <= '0;
            r_v4_len      <= '0;
            r_v4_val      <= '0;
            r_v4_zero     <= 1'b0;
            r_v6_ok       <= 1'b1;
            r_colon_total <= '0;
            r_v6_len      <= '0;
        end else if (o_pop) begin
            r_char_total  <= n_char_total;
            r_v4_ok       <= n_v4_ok;
            r_dot_total   <= n_dot_total;
            r_v4_len      <= n_v4_len;
            r_v4_val      <= n_v4_val;
            r_v4_zero     <= n_v4_zero;
            r_v6_ok       <= n_v6_ok;
            r_colon_total <= n_colon_total;
            r_v6_len      <= n_v6_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_tok.is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_tok.is_last) begin
            r_out_class <= w_class;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_class = r_out_class;

endmodule

[src/ip_address_text_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_text_classifier
// Classifies a byte stream as an IPv4 address, an IPv6 address or neither.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata           | tuser     | tlast
//  s_axis   | in        | [7:0] char_code | has_char  | is_last
//  m_axis   | out       | [1:0] class     | -         | -
//
//  One byte request is taken every cycle while the token queue is not full;
//  the back end applies the per-byte update to each token as it pops it.
//  The verdict is registered when the back end pops the last item of a
//  string from the four-entry token queue.
//  Synchronous active-low reset empties the queue and clears the output.
//  An output stall holds the verdict; input keeps flowing until the queue fills.
// ----------------------------------------------------------------------------
module ip_address_text_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tuser,   // [0] has_char
    input  logic       s_axis_tlast,   // is_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [1:0] address_class, [7:2] zero
);

    ipc_pkg::t_ipc_tok           w_push_tok;
    ipc_pkg::t_ipc_tok           w_pop_tok;
    logic                        w_push;
    logic                        w_pop;
    logic                        w_full;
    logic                        w_empty;
    logic [ipc_pkg::CLASS_W-1:0] w_class;

    ipc_front u_front (
        .i_valid      (s_axis_tvalid),
        .i_char_code  (s_axis_tdata),
        .i_has_char   (s_axis_tuser),
        .i_is_last    (s_axis_tlast),
        .i_queue_full (w_full),
        .o_ready      (s_axis_tready),
        .o_push       (w_push),
        .o_tok        (w_push_tok)
    );

    ipc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_tok),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_pop_tok)
    );

    ipc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_tok       (w_pop_tok),
        .o_pop       (w_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_class (w_class)
    );

    assign m_axis_tdata = {(8 - ipc_pkg::CLASS_W)'(0), w_class};

endmodule

[src/ipc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level assertions for the IP address text classifier.
// ----------------------------------------------------------------------------
module ipc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A stalled verdict stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict changed while stalled");

    // Only the three verdict codes may appear, with the padding at zero.
    a_out_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'd0) && (m_axis_tdata[1:0] != 2'd3))
        else $error("bad verdict code");

    // Reset leaves no verdict pending.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("verdict valid after reset");

    // The queue is empty after reset, so a request is taken at once.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("not ready after reset");

endmodule

bind ip_address_text_classifier ipc_checker u_ipc_checker (.*);

[sim/ip_address_text_classifier_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_text_classifier_tb
// Streams address strings, broken strings, overlong strings and random bytes
// into the classifier. A predictor in the bench computes the verdict of each
// string. Every verdict the block returns is compared with the oldest
// prediction. Both sides of the stream idle at random, the output is held off
// long enough to fill the block, and the sender waits for the results to drain.
// ----------------------------------------------------------------------------
module ip_address_text_classifier_tb;

    import ipc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        FLAW_NONE,
        FLAW_LEAD_ZERO,
        FLAW_BIG_GROUP,
        FLAW_EMPTY_GROUP,
        FLAW_LONG_GROUP,
        FLAW_GROUP_COUNT,
        FLAW_BAD_CHAR
    } t_text_flaw;

    // Running scan of the current string, as far as the bench predicts it.
    typedef struct {
        logic [5:0] chars;
        logic       v4_ok;
        logic [2:0] dots;
        logic [2:0] v4_len;
        logic [9:0] v4_val;
        logic       v4_lead0;
        logic       v6_ok;
        logic [3:0] colons;
        logic [2:0] v6_len;
    } t_addr_scan;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;  // [7:0] char_code
    logic       s_axis_tuser = 1'b0;   // [0] has_char
    logic       s_axis_tlast = 1'b0;   // is_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [1:0] address_class, [7:2] zero

    t_addr_scan         scan;
    logic [CLASS_W-1:0] verdict_q[$];
    logic [7:0]         text_q[$];

    int tx_max_gap = 0;
    int rx_max_stall = 0;
    int rx_hold_cycles = 0;
    int cycle_count = 0;
    int fail_count = 0;
    int items_sent = 0;
    int v4_seen = 0;
    int v6_seen = 0;
    int none_seen = 0;

    ip_address_text_classifier u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Verdict predictor
    // ------------------------------------------------------------------------
    function automatic void scan_clear();
        scan.chars    = '0;
        scan.v4_ok    = 1'b1;
        scan.dots     = '0;
        scan.v4_len   = '0;
        scan.v4_val   = '0;
        scan.v4_lead0 = 1'b0;
        scan.v6_ok    = 1'b1;
        scan.colons   = '0;
        scan.v6_len   = '0;
    endfunction

    function automatic logic v4_group_good();
        if (scan.v4_len == 0 || scan.v4_len > V4_MAX_DIGITS)
            return 1'b0;
        if (scan.v4_lead0 && scan.v4_len > 1)
            return 1'b0;
        return scan.v4_val <= V4_MAX_VALUE;
    endfunction

    function automatic logic v6_group_good();
        return scan.v6_len >= 1 && scan.v6_len <= V6_MAX_DIGITS;
    endfunction

    function automatic logic is_hex_char(logic [7:0] ch);
        return (ch >= ASCII_0 && ch <= ASCII_9) || (ch >= ASCII_LA && ch <= ASCII_LF) ||
               (ch >= ASCII_UA && ch <= ASCII_UF);
    endfunction

    function automatic void scan_byte(logic [7:0] ch);
        if (scan.chars < CHAR_SAT)
            scan.chars++;

        if (ch == ASCII_DOT) begin
            if (scan.dots < DOT_SAT)
                scan.dots++;
            if (!v4_group_good())
                scan.v4_ok = 1'b0;
            scan.v4_len   = '0;
            scan.v4_val   = '0;
            scan.v4_lead0 = 1'b0;
        end else if (ch >= ASCII_0 && ch <= ASCII_9) begin
            if (scan.v4_len == 0)
                scan.v4_lead0 = (ch == ASCII_0);
            // Only the first three digits feed the group value.
            if (scan.v4_len < V4_MAX_DIGITS)
                scan.v4_val = scan.v4_val * 10'd10 + 10'(ch - ASCII_0);
            if (scan.v4_len < V4_LEN_SAT)
                scan.v4_len++;
        end else begin
            scan.v4_ok = 1'b0;
        end

        if (ch == ASCII_COLON) begin
            if (scan.colons < COLON_SAT)
                scan.colons++;
            if (!v6_group_good())
                scan.v6_ok = 1'b0;
            scan.v6_len = '0;
        end else if (is_hex_char(ch)) begin
            if (scan.v6_len < V6_LEN_SAT)
                scan.v6_len++;
        end else begin
            scan.v6_ok = 1'b0;
        end
    endfunction

    function automatic logic [CLASS_W-1:0] scan_verdict();
        logic v4;
        logic v6;
        if (scan.chars == 0)
            return CLASS_NONE;
        v4 = scan.v4_ok && scan.dots == V4_DOTS && scan.chars <= V4_MAX_CHARS &&
             v4_group_good();
        v6 = scan.v6_ok && scan.colons == V6_COLONS && scan.chars <= V6_MAX_CHARS &&
             v6_group_good();
        if (v4)
            return CLASS_V4;
        if (v6)
            return CLASS_V6;
        return CLASS_NONE;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    function automatic void text_add(input logic [7:0] ch);
        text_q.insert(text_q.size(), ch);
    endfunction

    task automatic send_byte(input logic [7:0] ch, input logic has, input logic last);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= has;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        items_sent++;
        if (has)
            scan_byte(ch);
        if (last) begin
            verdict_q.insert(verdict_q.size(), scan_verdict());
            scan_clear();
        end
    endtask

    task automatic sender_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_for_verdicts();
        sender_idle();
        while (verdict_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_pacing();
        tx_max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 11;
        rx_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 11;
    endtask

    // Sends text_q as one string. Empty requests without a character are mixed
    // in now and then, and some strings end on such a request instead.
    task automatic send_text(input logic trailing_end);
        int n;
        n = text_q.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_byte(text_q[i], 1'b1, !trailing_end && i == n - 1);
        end
        if (trailing_end || n == 0)
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic load_text(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            text_add(s[i]);
    endtask

    task automatic append_dec(input int v);
        if (v >= 100)
            text_add(8'(ASCII_0 + v / 100));
        if (v >= 10)
            text_add(8'(ASCII_0 + (v / 10) % 10));
        text_add(8'(ASCII_0 + v % 10));
    endtask

    task automatic append_hex();
        int h;
        h = $urandom_range(0, 15);
        if (h < 10)
            text_add(8'(ASCII_0 + h));
        else if ($urandom_range(0, 1) != 0)
            text_add(8'(ASCII_UA + h - 10));
        else
            text_add(8'(ASCII_LA + h - 10));
    endtask

    function automatic int pick_octet();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 255;
            2: return $urandom_range(1, 9);
            3: return $urandom_range(10, 99);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [7:0] pick_addr_char();
        case ($urandom_range(0, 5))
            0: return ASCII_DOT;
            1: return ASCII_COLON;
            2, 3: return 8'(ASCII_0 + $urandom_range(0, 9));
            4: return 8'(ASCII_LA + $urandom_range(0, 5));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic corrupt_one_char();
        if (text_q.size() != 0)
            text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    task automatic build_v4(input t_text_flaw flaw);
        int groups;
        int target;
        groups = 4;
        if (flaw == FLAW_GROUP_COUNT)
            groups = ($urandom_range(0, 1) != 0) ? 3 : 5;
        target = $urandom_range(0, groups - 1);
        text_q.delete();
        for (int g = 0; g < groups; g++) begin
            if (g != 0)
                text_add(ASCII_DOT);
            if (g == target) begin
                case (flaw)
                    FLAW_LEAD_ZERO: begin
                        text_add(ASCII_0);
                        append_dec($urandom_range(0, 99));
                    end
                    FLAW_BIG_GROUP: append_dec($urandom_range(256, 999));
                    FLAW_EMPTY_GROUP: ;
                    FLAW_LONG_GROUP: begin
                        repeat ($urandom_range(4, 7))
                            text_add(8'(ASCII_0 + $urandom_range(0, 9)));
                    end
                    default: append_dec(pick_octet());
                endcase
            end else begin
                append_dec(pick_octet());
            end
        end
        if (flaw == FLAW_BAD_CHAR)
            corrupt_one_char();
    endtask

    task automatic build_v6(input t_text_flaw flaw);
        int groups;
        int target;
        int len;
        groups = 8;
        if (flaw == FLAW_GROUP_COUNT)
            groups = ($urandom_range(0, 1) != 0) ? 7 : 9;
        target = $urandom_range(0, groups - 1);
        text_q.delete();
        for (int g = 0; g < groups; g++) begin
            if (g != 0)
                text_add(ASCII_COLON);
            len = ($urandom_range(0, 3) == 0) ? 4 : $urandom_range(1, 4);
            if (g == target) begin
                case (flaw)
                    FLAW_EMPTY_GROUP: len = 0;
                    FLAW_LONG_GROUP, FLAW_BIG_GROUP: len = $urandom_range(5, 9);
                    FLAW_LEAD_ZERO: begin
                        // Leading zeros are legal in a hex group.
                        text_add(ASCII_0);
                        len = $urandom_range(0, 3);
                    end
                    default: ;
                endcase
            end
            repeat (len) append_hex();
        end
        if (flaw == FLAW_BAD_CHAR)
            corrupt_one_char();
    endtask

    function automatic t_text_flaw pick_flaw();
        if ($urandom_range(0, 9) < 4)
            return FLAW_NONE;
        return t_text_flaw'($urandom_range(FLAW_LEAD_ZERO, FLAW_BAD_CHAR));
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles != 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, rx_max_stall);
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid && rx_hold_cycles == 0)
                @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        logic [CLASS_W-1:0] want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $error("address_class: expected none, got %0d", m_axis_tdata[CLASS_W-1:0]);
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[CLASS_W-1:0] !== want) begin
                    $error("address_class: expected %0d, got %0d", want,
                           m_axis_tdata[CLASS_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[7:CLASS_W] !== '0) begin
                    $error("tdata padding: expected 0, got %0h", m_axis_tdata[7:CLASS_W]);
                    fail_count++;
                end
                case (want)
                    CLASS_V4: v4_seen++;
                    CLASS_V6: v6_seen++;
                    default: none_seen++;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(ASCII_COLON, 1'b0, 1'b1);
        load_text("0.0.0.0");
        send_text(1'b0);
        load_text("1:2:3:4:5:6:7:8");
        send_text(1'b0);
    endtask

    task automatic test_ipv4_text(input int count);
        load_text("255.255.255.255");
        send_text(1'b0);
        load_text("255.255.255.256");
        send_text(1'b0);
        for (int i = 0; i < count; i++) begin
            if (i % 10 == 0)
                set_pacing();
            build_v4(pick_flaw());
            send_text($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic test_ipv6_text(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 8 == 0)
                set_pacing();
            build_v6(pick_flaw());
            send_text($urandom_range(0, 3) == 0);
        end
    endtask

    // Overlong strings that saturate the character, dot and colon counters.
    task automatic test_overlong_text(input int count);
        for (int i = 0; i < count; i++) begin
            set_pacing();
            text_q.delete();
            case (i % 3)
                0: repeat ($urandom_range(16, 90)) text_add(pick_addr_char());
                1: begin
                    repeat ($urandom_range(9, 14)) begin
                        repeat (4) append_hex();
                        text_add(ASCII_COLON);
                    end
                end
                default: begin
                    repeat ($urandom_range(5, 9)) begin
                        append_dec($urandom_range(0, 255));
                        text_add(ASCII_DOT);
                    end
                    append_dec(7);
                end
            endcase
            send_text($urandom_range(0, 1) != 0);
        end
    endtask

    task automatic test_byte_noise(input int count);
        logic [7:0] ch;
        set_pacing();
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);
        for (int i = 0; i < count; i++) begin
            ch = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255)) : pick_addr_char();
            send_byte(ch, $urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0);
        end
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // The receiver holds off while the sender keeps offering short strings,
    // so the token queue fills and the block drops its ready.
    task automatic test_output_stall_fill();
        wait_for_verdicts();
        tx_max_gap = 0;
        rx_max_stall = 3;
        rx_hold_cycles = 80;
        for (int i = 0; i < 8; i++) begin
            build_v4(($urandom_range(0, 1) != 0) ? FLAW_NONE : pick_flaw());
            send_text(1'b0);
        end
    endtask

    task automatic test_pause_until_drained();
        for (int i = 0; i < 6; i++) begin
            set_pacing();
            wait_for_verdicts();
            if (i % 2 == 0)
                build_v4(pick_flaw());
            else
                build_v6(pick_flaw());
            send_text(i % 3 == 0);
        end
    endtask

    initial begin
        scan_clear();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_ipv4_text(50);
        test_ipv6_text(14);
        test_overlong_text(6);
        test_byte_noise(150);
        test_output_stall_fill();
        test_pause_until_drained();

        wait_for_verdicts();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d requests; checked %0d IPv4, %0d IPv6 and %0d other verdicts,",
                 items_sent, v4_seen, v6_seen, none_seen);
        $display("with random idling, a long output hold-off and drained pauses.");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
